/* src/rep_pkg.sv */
`default_nettype none
package rep_pkg;

  localparam int ROUTE_DEPTH = 256;
  localparam int FRAC_BITS   = 16;
  localparam int COORD_W     = 24;
  localparam int MAX_W       = 23;
  localparam int LIM_W       = 2 * MAX_W;
  localparam int CNT_W       = $clog2(ROUTE_DEPTH + 1);
  localparam int IDX_W       = $clog2(ROUTE_DEPTH);
  localparam int DIFF_W      = COORD_W + 1;
  localparam int MUL_W       = COORD_W + 3;
  localparam int ACC_W       = 2 * MUL_W;
  localparam int T_W         = FRAC_BITS + 1;
  localparam int DCNT_W      = $clog2(FRAC_BITS + 1);
  localparam int PT_W        = 3 * COORD_W;

  localparam logic [1:0] SRC_ROUTE = 2'd0;
  localparam logic [1:0] SRC_HELD  = 2'd1;
  localparam logic [1:0] SRC_INPUT = 2'd2;

  localparam logic [T_W-1:0] T_ONE = {1'b1, {FRAC_BITS{1'b0}}};

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
  } point_t;

  typedef struct packed {
    logic                      done;
    logic [ACC_W-1:0]          d2;
    logic signed [COORD_W-1:0] z;
  } seg_res_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD0,
    ST_START,
    ST_FETCH,
    ST_EVAL,
    ST_FINAL
  } ctrl_state_e;

  typedef enum logic [2:0] {
    EV_IDLE,
    EV_LEN,
    EV_DIVS,
    EV_DIV,
    EV_PROJ,
    EV_DIST,
    EV_DONE
  } eval_state_e;

endpackage
`default_nettype wire

/* src/rep_route_ram.sv */
`default_nettype none
module rep_route_ram #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 72
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]              rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

/* src/rep_divider.sv */
`default_nettype none
module rep_divider (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               start_i,
  input  wire logic [rep_pkg::ACC_W-1:0]          num_i,
  input  wire logic [rep_pkg::ACC_W-1:0]          den_i,
  output logic                                    done_o,
  output logic [rep_pkg::FRAC_BITS-1:0]           quot_o
);
  import rep_pkg::*;

  logic [ACC_W-1:0]     rem_q, rem_d, den_q, rem_sh;
  logic [FRAC_BITS-1:0] quot_q, quot_d;
  logic [DCNT_W-1:0]    cnt_q;
  logic                 busy_q, done_q;

  always_comb begin
    rem_sh = rem_q << 1;
    if (rem_sh >= den_q) begin
      rem_d  = rem_sh - den_q;
      quot_d = {quot_q[FRAC_BITS-2:0], 1'b1};
    end else begin
      rem_d  = rem_sh;
      quot_d = {quot_q[FRAC_BITS-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + DCNT_W'(1);
        if (cnt_q == DCNT_W'(FRAC_BITS - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= num_i;
      den_q  <= den_i;
      quot_q <= '0;
    end else if (busy_q) begin
      rem_q  <= rem_d;
      quot_q <= quot_d;
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule
`default_nettype wire

/* src/rep_seg_eval.sv */
`default_nettype none
module rep_seg_eval (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire rep_pkg::point_t   seg_s_i,
  input  wire rep_pkg::point_t   seg_e_i,
  input  wire rep_pkg::point_t   query_i,
  output rep_pkg::seg_res_t      res_o
);
  import rep_pkg::*;

  eval_state_e state_q, state_d;
  logic [2:0]  step_q;
  logic        last_step;

  logic signed [DIFF_W-1:0]  dx_q, dy_q, dz_q, rx_q, ry_q;
  logic signed [COORD_W-1:0] sz_q, z_q;
  logic signed [ACC_W-1:0]   len2_q, n_q, d2_q, mul_q, ofs;
  logic signed [MUL_W-1:0]   mul_a, mul_b, ox_q, oy_q, t_s;
  logic [T_W-1:0]            t_q;
  logic                      div_start, div_done;
  logic [FRAC_BITS-1:0]      div_quot;

  rep_divider u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (ACC_W'($unsigned(n_q))),
    .den_i   (ACC_W'($unsigned(len2_q))),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  assign t_s = MUL_W'($signed({1'b0, t_q}));
  assign ofs = mul_q >>> FRAC_BITS;

  always_comb begin
    last_step = 1'b0;
    case (state_q)
      EV_LEN:  last_step = (step_q == 3'd4);
      EV_PROJ: last_step = (step_q == 3'd3);
      EV_DIST: last_step = (step_q == 3'd2);
      default: last_step = 1'b0;
    endcase
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      EV_IDLE: if (start_i) state_d = EV_LEN;
      EV_LEN:  if (last_step) state_d = EV_DIVS;
      EV_DIVS: begin
        if (len2_q == '0 || n_q[ACC_W-1] || n_q == '0 || n_q >= len2_q) state_d = EV_PROJ;
        else state_d = EV_DIV;
      end
      EV_DIV:  if (div_done) state_d = EV_PROJ;
      EV_PROJ: if (last_step) state_d = EV_DIST;
      EV_DIST: if (last_step) state_d = EV_DONE;
      EV_DONE: state_d = EV_IDLE;
      default: state_d = EV_IDLE;
    endcase
  end

  // multiplier operands and divider launch
  always_comb begin
    mul_a     = '0;
    mul_b     = '0;
    div_start = 1'b0;
    case (state_q)
      EV_LEN: begin
        case (step_q)
          3'd0: begin mul_a = MUL_W'(dx_q); mul_b = MUL_W'(dx_q); end
          3'd1: begin mul_a = MUL_W'(dy_q); mul_b = MUL_W'(dy_q); end
          3'd2: begin mul_a = MUL_W'(rx_q); mul_b = MUL_W'(dx_q); end
          3'd3: begin mul_a = MUL_W'(ry_q); mul_b = MUL_W'(dy_q); end
          default: begin mul_a = '0; mul_b = '0; end
        endcase
      end
      EV_DIVS: div_start = !(len2_q == '0 || n_q[ACC_W-1] || n_q == '0 || n_q >= len2_q);
      EV_PROJ: begin
        case (step_q)
          3'd0: begin mul_a = t_s; mul_b = MUL_W'(dx_q); end
          3'd1: begin mul_a = t_s; mul_b = MUL_W'(dy_q); end
          3'd2: begin mul_a = t_s; mul_b = MUL_W'(dz_q); end
          default: begin mul_a = '0; mul_b = '0; end
        endcase
      end
      EV_DIST: begin
        case (step_q)
          3'd0: begin mul_a = ox_q; mul_b = ox_q; end
          3'd1: begin mul_a = oy_q; mul_b = oy_q; end
          default: begin mul_a = '0; mul_b = '0; end
        endcase
      end
      default: begin
        mul_a     = '0;
        mul_b     = '0;
        div_start = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= EV_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      if (state_d != state_q) step_q <= '0;
      else                    step_q <= step_q + 3'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    mul_q <= mul_a * mul_b;
    if (state_q == EV_IDLE && start_i) begin
      dx_q <= DIFF_W'(seg_e_i.x) - DIFF_W'(seg_s_i.x);
      dy_q <= DIFF_W'(seg_e_i.y) - DIFF_W'(seg_s_i.y);
      dz_q <= DIFF_W'(seg_e_i.z) - DIFF_W'(seg_s_i.z);
      rx_q <= DIFF_W'(query_i.x) - DIFF_W'(seg_s_i.x);
      ry_q <= DIFF_W'(query_i.y) - DIFF_W'(seg_s_i.y);
      sz_q <= seg_s_i.z;
    end
    case (state_q)
      EV_LEN: begin
        case (step_q)
          3'd1: len2_q <= mul_q;
          3'd2: len2_q <= len2_q + mul_q;
          3'd3: n_q    <= mul_q;
          3'd4: n_q    <= n_q + mul_q;
          default: ;
        endcase
      end
      EV_DIVS: begin
        if (len2_q == '0 || n_q[ACC_W-1] || n_q == '0) t_q <= '0;
        else if (n_q >= len2_q)                        t_q <= T_ONE;
      end
      EV_DIV: if (div_done) t_q <= {1'b0, div_quot};
      EV_PROJ: begin
        case (step_q)
          3'd1: ox_q <= MUL_W'(ACC_W'(rx_q) - ofs);
          3'd2: oy_q <= MUL_W'(ACC_W'(ry_q) - ofs);
          3'd3: z_q  <= COORD_W'(ACC_W'(sz_q) + ofs);
          default: ;
        endcase
      end
      EV_DIST: begin
        case (step_q)
          3'd1: d2_q <= mul_q;
          3'd2: d2_q <= d2_q + mul_q;
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  assign res_o.done = (state_q == EV_DONE);
  assign res_o.d2   = $unsigned(d2_q);
  assign res_o.z    = z_q;

endmodule
`default_nettype wire

/* src/route_elevation_projector_top.sv */
// Channel  Signals                                          Direction
// in       in_valid_i/in_ready_o, func_i, pos_*_i, first_point_i   into block
// out      out_valid_o/out_ready_i, out_z_o, z_source_o             out of block
// cfg      cfg_we_i, cfg_wdata_i (max_lateral_mm)                  into block
//
// A query uses the one-bit-per-cycle divider only when the Q1.16 projection
// parameter of a segment does not clamp to 0 or 1; an empty route skips
// the segment loop. All nine products of a segment share one 27x27 multiplier.
// Reset clears the point count and the held z and sets the limit to 5000; route
// memory is not cleared. A query whose result cannot leave waits in its final state.
`default_nettype none
module route_elevation_projector_top (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               in_valid_i,
  output logic                                    in_ready_o,
  input  wire logic                               func_i,
  input  wire logic signed [rep_pkg::COORD_W-1:0] pos_x_i,
  input  wire logic signed [rep_pkg::COORD_W-1:0] pos_y_i,
  input  wire logic signed [rep_pkg::COORD_W-1:0] pos_z_i,
  input  wire logic                               first_point_i,
  output logic                                    out_valid_o,
  input  wire logic                               out_ready_i,
  output logic signed [rep_pkg::COORD_W-1:0]      out_z_o,
  output logic [1:0]                              z_source_o,
  input  wire logic                               cfg_we_i,
  input  wire logic [rep_pkg::MAX_W-1:0]          cfg_wdata_i
);
  import rep_pkg::*;

  ctrl_state_e state_q, state_d;

  logic [CNT_W-1:0]          count_q, seg_q, cnt_base;
  logic [MAX_W-1:0]          max_q;
  logic [LIM_W-1:0]          lim2_q;
  point_t                    q_q, start_q, end_q, rdata, ev_s, ev_e, in_pt;
  logic                      best_valid_q, held_valid_q, out_valid_q;
  logic [ACC_W-1:0]          best_d2_q;
  logic signed [COORD_W-1:0] best_z_q, held_z_q, out_z_q;
  logic [1:0]                out_src_q;
  logic                      in_acc, ram_we, ram_re, ev_start, seg_last, fire, fallback;
  logic [IDX_W-1:0]          ram_raddr;
  seg_res_t                  res;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign in_pt      = '{x: pos_x_i, y: pos_y_i, z: pos_z_i};
  assign cnt_base   = first_point_i ? '0 : count_q;
  assign ram_we     = in_acc && !func_i && (cnt_base < CNT_W'(ROUTE_DEPTH));
  assign seg_last   = (count_q == CNT_W'(1)) ||
                      ((CNT_W + 1)'(seg_q) + (CNT_W + 1)'(2) >= (CNT_W + 1)'(count_q));
  assign fire       = (state_q == ST_FINAL) && (!out_valid_q || out_ready_i);
  assign fallback   = (count_q == '0) || !best_valid_q ||
                      (best_d2_q > ACC_W'(lim2_q));

  rep_route_ram #(.DEPTH(ROUTE_DEPTH), .WIDTH(PT_W)) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (cnt_base[IDX_W-1:0]),
    .wdata_i (in_pt),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (rdata)
  );

  rep_seg_eval u_eval (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (ev_start),
    .seg_s_i (ev_s),
    .seg_e_i (ev_e),
    .query_i (q_q),
    .res_o   (res)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc && func_i) state_d = (count_q == '0) ? ST_FINAL : ST_RD0;
      end
      ST_RD0:   state_d = ST_START;
      ST_START: state_d = (count_q == CNT_W'(1)) ? ST_EVAL : ST_FETCH;
      ST_FETCH: state_d = ST_EVAL;
      ST_EVAL:  if (res.done) state_d = seg_last ? ST_FINAL : ST_FETCH;
      ST_FINAL: if (fire) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // memory reads and segment launch
  always_comb begin
    ram_re    = 1'b0;
    ram_raddr = '0;
    ev_start  = 1'b0;
    ev_s      = start_q;
    ev_e      = rdata;
    case (state_q)
      ST_RD0: ram_re = 1'b1;
      ST_START: begin
        if (count_q == CNT_W'(1)) begin
          ev_start = 1'b1;
          ev_s     = rdata;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = IDX_W'(1);
        end
      end
      ST_FETCH: ev_start = 1'b1;
      ST_EVAL: begin
        if (res.done && !seg_last) begin
          ram_re    = 1'b1;
          ram_raddr = IDX_W'(seg_q + CNT_W'(2));
        end
      end
      default: begin
        ram_re   = 1'b0;
        ev_start = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      count_q      <= '0;
      max_q        <= MAX_W'(5000);
      held_valid_q <= 1'b0;
      held_z_q     <= '0;
      out_valid_q  <= 1'b0;
      best_valid_q <= 1'b0;
      seg_q        <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) max_q <= cfg_wdata_i;
      if (ram_we) count_q <= cnt_base + CNT_W'(1);
      if (in_acc && func_i) begin
        best_valid_q <= 1'b0;
        seg_q        <= '0;
      end
      if (state_q == ST_EVAL && res.done) begin
        if (!best_valid_q || res.d2 < best_d2_q) best_valid_q <= 1'b1;
        if (!seg_last) seg_q <= seg_q + CNT_W'(1);
      end
      if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;
      if (fire) begin
        out_valid_q <= 1'b1;
        if (!fallback) begin
          held_valid_q <= 1'b1;
          held_z_q     <= best_z_q;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    lim2_q <= LIM_W'(max_q) * LIM_W'(max_q);
    if (in_acc && func_i) q_q <= in_pt;
    if (state_q == ST_START) start_q <= rdata;
    if (state_q == ST_FETCH) end_q <= rdata;
    if (state_q == ST_EVAL && res.done) begin
      if (!best_valid_q || res.d2 < best_d2_q) begin
        best_d2_q <= res.d2;
        best_z_q  <= res.z;
      end
      // advance: this end point starts the next segment
      if (!seg_last) start_q <= end_q;
    end
    if (fire) begin
      if (!fallback) begin
        out_z_q   <= best_z_q;
        out_src_q <= SRC_ROUTE;
      end else if (held_valid_q) begin
        out_z_q   <= held_z_q;
        out_src_q <= SRC_HELD;
      end else begin
        out_z_q   <= q_q.z;
        out_src_q <= SRC_INPUT;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_z_o     = out_z_q;
  assign z_source_o  = out_src_q;

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(ROUTE_DEPTH))
    else $error("point count beyond route depth");

  a_done_in_eval: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res.done |-> state_q == ST_EVAL)
    else $error("segment result outside evaluation");

  a_route_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && z_source_o == SRC_ROUTE |-> held_valid_q)
    else $error("projected result without held z");

  a_held_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$fell(held_valid_q))
    else $error("held z lost");

endmodule
`default_nettype wire
